### hw/rtl/lec_pkg.sv
// ----------------------------------------------------------------------------
// lec_pkg: shared types and constants of the line ending converter
// Terminator codes, register indexes, byte constants and the queue entry
// that carries one or two output bytes from the front to the back.
// ----------------------------------------------------------------------------
package lec_pkg;

  // terminator / mode codes
  localparam logic [1:0] TERM_CR   = 2'd0;
  localparam logic [1:0] TERM_LF   = 2'd1;
  localparam logic [1:0] TERM_CRLF = 2'd2;
  localparam logic [1:0] MODE_HOST = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_FROM_MODE = 2'd0;
  localparam logic [1:0] REG_TO_MODE   = 2'd1;
  localparam logic [1:0] REG_HOST_TERM = 2'd2;

  localparam logic [7:0] BYTE_CR = 8'h0d;
  localparam logic [7:0] BYTE_LF = 8'h0a;

  // one queued run of output bytes (one or two)
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } lec_entry_t;

  // map a mode to a concrete terminator; host code 3 reads as LF
  function automatic logic [1:0] resolve(input logic [1:0] mode,
                                         input logic [1:0] host);
    logic [1:0] t;
    t = (mode == MODE_HOST) ? host : mode;
    return (t == MODE_HOST) ? TERM_LF : t;
  endfunction

endpackage

### hw/rtl/line_ending_converter.sv
// ----------------------------------------------------------------------------
// line_ending_converter: rewrites line terminators of a text byte stream
// Input beats carry one byte (s_tdata) and an end-of-data mark (s_tlast).
// Each beat yields zero, one or two output bytes on the m_ side; m_tlast
// marks the final byte produced by one input beat. The cfg port writes the
// source mode (index 0), target mode (1) and host terminator (2); any
// register write drops a held CR. The user must make writes only while the
// block is idle; the block itself does not enforce this. Each beat's run
// is registered in the queue and its first byte is shown at the queue head
// once the runs before it are sent. The input side takes one beat per cycle
// while the queue has room; the output side sends one byte per cycle while
// m_tready is high, so sustained throughput is set by the output byte count.
// If m_tready stays low the queue fills (QUEUE_DEPTH runs) and s_tready
// drops; nothing is lost. Reset empties the queue, clears a held CR and
// sets both modes to host with the host terminator LF.
// ----------------------------------------------------------------------------
module line_ending_converter import lec_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] in_byte
  input  logic       s_tlast,    // end_of_data
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic       m_tlast     // last_in_run
);

  logic       q_full;
  logic       q_push;
  lec_entry_t q_entry;
  logic       q_pop;
  logic       q_valid;
  lec_entry_t q_head;

  lec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_byte     (s_tdata),
    .end_of_data (s_tlast),
    .in_ready    (s_tready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  lec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  lec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .last_in_run (m_tlast)
  );

endmodule

### hw/rtl/lec_front.sv
// ----------------------------------------------------------------------------
// lec_front: input side of the line ending converter
// Holds the configuration and the held-CR flag, classifies each input beat
// and turns it into a queue entry of one or two output bytes, or into none.
// ----------------------------------------------------------------------------
module lec_front import lec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       end_of_data,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output lec_entry_t q_entry
);

  logic [1:0] from_mode;
  logic [1:0] to_mode;
  logic [1:0] host_term;
  logic       pending_cr;
  logic       pending_cr_next;

  logic       accept;
  logic       passthru;
  logic [1:0] src;
  logic [1:0] dst;
  logic [1:0] n_main;
  logic [7:0] m0;
  logic [7:0] m1;
  logic       pend_main;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign passthru = (from_mode == MODE_HOST) && (to_mode == MODE_HOST);
  assign src      = resolve(from_mode, host_term);
  assign dst      = resolve(to_mode, host_term);

  // main conversion of the beat, before the end-of-data flush
  always_comb begin
    n_main    = 2'd0;
    m0        = in_byte;
    m1        = in_byte;
    pend_main = pending_cr;
    if (passthru) begin
      pend_main = 1'b0;
      n_main    = 2'd1;
    end else if (src == TERM_CRLF) begin
      if (pending_cr) begin
        if (in_byte == BYTE_LF) begin
          pend_main = 1'b0;
          unique case (dst)
            TERM_CR:   begin n_main = 2'd1; m0 = BYTE_CR; end
            TERM_LF:   begin n_main = 2'd1; m0 = BYTE_LF; end
            default:   begin n_main = 2'd2; m0 = BYTE_CR; m1 = BYTE_LF; end
          endcase
        end else begin
          m0 = BYTE_CR;
          if (in_byte == BYTE_CR) begin
            pend_main = 1'b1;
            n_main    = 2'd1;
          end else begin
            pend_main = 1'b0;
            n_main    = 2'd2;
            m1        = in_byte;
          end
        end
      end else if (in_byte == BYTE_CR) begin
        pend_main = 1'b1;
      end else begin
        n_main = 2'd1;
      end
    end else begin
      pend_main = 1'b0;
      if ((src == TERM_CR && in_byte == BYTE_CR) ||
          (src == TERM_LF && in_byte == BYTE_LF)) begin
        unique case (dst)
          TERM_CR:   begin n_main = 2'd1; m0 = BYTE_CR; end
          TERM_LF:   begin n_main = 2'd1; m0 = BYTE_LF; end
          default:   begin n_main = 2'd2; m0 = BYTE_CR; m1 = BYTE_LF; end
        endcase
      end else begin
        n_main = 2'd1;
      end
    end
  end

  // end-of-data flush of a held CR, then build the queue entry
  always_comb begin
    q_entry.b0      = m0;
    q_entry.b1      = m1;
    q_entry.two     = (n_main == 2'd2);
    q_push          = accept && (n_main != 2'd0);
    pending_cr_next = pend_main;
    if (end_of_data) begin
      pending_cr_next = 1'b0;
      if (pend_main) begin
        // a held CR means at most one byte came before it
        q_push = accept;
        if (n_main == 2'd0) begin
          q_entry.b0 = BYTE_CR;
        end else begin
          q_entry.b1  = BYTE_CR;
          q_entry.two = 1'b1;
        end
      end
    end
  end

  // configuration registers and held-CR flag
  always_ff @(posedge clk) begin
    if (rst) begin
      from_mode  <= MODE_HOST;
      to_mode    <= MODE_HOST;
      host_term  <= TERM_LF;
      pending_cr <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FROM_MODE: begin from_mode <= cfg_data; pending_cr <= 1'b0; end
        REG_TO_MODE:   begin to_mode   <= cfg_data; pending_cr <= 1'b0; end
        REG_HOST_TERM: begin host_term <= cfg_data; pending_cr <= 1'b0; end
        default:       ;
      endcase
    end else if (accept) begin
      pending_cr <= pending_cr_next;
    end
  end

endmodule

### hw/rtl/lec_queue.sv
// ----------------------------------------------------------------------------
// lec_queue: entry queue between front and back
// Small register FIFO of output runs; head entry is read straight from the storage registers.
// ----------------------------------------------------------------------------
module lec_queue import lec_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lec_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output lec_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lec_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/lec_back.sv
// ----------------------------------------------------------------------------
// lec_back: output side of the line ending converter
// Walks the bytes of the head entry, one beat per byte, and marks the
// final byte of each run.
// ----------------------------------------------------------------------------
module lec_back import lec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  lec_entry_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_in_run
);

  logic second;   // showing the second byte of the head entry
  logic beat;

  assign out_valid   = q_valid;
  assign out_byte    = second ? q_head.b1 : q_head.b0;
  assign last_in_run = second || !q_head.two;
  assign beat        = out_valid && out_ready;
  assign q_pop       = beat && last_in_run;

  // byte position within the run
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (beat) begin
      second <= !last_in_run;
    end
  end

endmodule
